// ===== hw/rtl/pwc_pkg.sv =====
`default_nettype none
package pwc_pkg;

  // Axes handled by the wall logic, and axes carried on the ports
  localparam int DIMS = 3;
  localparam int AXES = 3;

  // Fixed point scale of time_step and min_distance_factor
  localparam int FRAC_BITS = 16;

  // Pipeline depth, one valid bit per stage
  localparam int NSTAGES = 11;

  // Velocity times time step: 32 x 17 signed product and its scaled result
  localparam int PROD_W = 49;
  localparam int DV_W = PROD_W - FRAC_BITS;

  // Collision distance times factor: 31 x 16 unsigned product plus carry
  localparam int MPROD_W = 48;
  localparam int MIND_W = MPROD_W - FRAC_BITS;

  // Width of the exact sums and compares
  localparam int MAXW_A = (MIND_W + 1 > DV_W) ? MIND_W + 1 : DV_W;
  localparam int WIDE_W = ((MAXW_A > 33) ? MAXW_A : 33) + 2;

  // Round to nearest, ties toward plus infinity, before the shift
  localparam logic signed [PROD_W-1:0] PHALF =
    {{(PROD_W-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};
  localparam logic [MPROD_W-1:0] MHALF =
    {{(MPROD_W-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};

  // Saturation bounds in the wide format
  localparam logic signed [WIDE_W-1:0] SAT_MAX_W = {{(WIDE_W-31){1'b0}}, {31{1'b1}}};
  localparam logic signed [WIDE_W-1:0] SAT_MIN_W = {{(WIDE_W-31){1'b1}}, {31{1'b0}}};

  // Configuration port
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [31:0] UPPER_RST = 32'h0001_0000;
  localparam logic [5:0] WALLS_RST = 6'd55;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOWER_X,
    CFG_LOWER_Y,
    CFG_LOWER_Z,
    CFG_UPPER_X,
    CFG_UPPER_Y,
    CFG_UPPER_Z,
    CFG_FACTOR,
    CFG_WALLS
  } cfg_idx_e;

  typedef struct packed {
    logic [AXES-1:0][31:0] lower;
    logic [AXES-1:0][31:0] upper;
    logic [15:0]           factor;
    logic [2*AXES-1:0]     walls;
  } cfg_t;

  function automatic logic signed [WIDE_W-1:0] sx32(input logic [31:0] a);
    return {{(WIDE_W-32){a[31]}}, a};
  endfunction

  function automatic logic signed [WIDE_W-1:0] sxdv(input logic [DV_W-1:0] a);
    return {{(WIDE_W-DV_W){a[DV_W-1]}}, a};
  endfunction

  function automatic logic signed [WIDE_W-1:0] zx31(input logic [30:0] a);
    return {{(WIDE_W-31){1'b0}}, a};
  endfunction

  function automatic logic signed [WIDE_W-1:0] zxm(input logic [MIND_W-1:0] a);
    return {{(WIDE_W-MIND_W){1'b0}}, a};
  endfunction

  function automatic logic [31:0] sat32(input logic signed [WIDE_W-1:0] a);
    logic [31:0] r;
    if (a > SAT_MAX_W) begin
      r = 32'h7FFF_FFFF;
    end else if (a < SAT_MIN_W) begin
      r = 32'h8000_0000;
    end else begin
      r = a[31:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/pwc_cfg.sv =====
`default_nettype none
module pwc_cfg (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [pwc_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [pwc_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output pwc_pkg::cfg_t                         cfg_o
);

  pwc_pkg::cfg_t cfg_q, cfg_d;

  // Decode the register index and update one field
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (pwc_pkg::cfg_idx_e'(cfg_idx_i))
        pwc_pkg::CFG_LOWER_X: cfg_d.lower[0] = cfg_data_i[31:0];
        pwc_pkg::CFG_LOWER_Y: cfg_d.lower[1] = cfg_data_i[31:0];
        pwc_pkg::CFG_LOWER_Z: cfg_d.lower[2] = cfg_data_i[31:0];
        pwc_pkg::CFG_UPPER_X: cfg_d.upper[0] = cfg_data_i[31:0];
        pwc_pkg::CFG_UPPER_Y: cfg_d.upper[1] = cfg_data_i[31:0];
        pwc_pkg::CFG_UPPER_Z: cfg_d.upper[2] = cfg_data_i[31:0];
        pwc_pkg::CFG_FACTOR:  cfg_d.factor = cfg_data_i[15:0];
        pwc_pkg::CFG_WALLS:   cfg_d.walls = cfg_data_i[2*pwc_pkg::AXES-1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  // Hold the register file, defaults on reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.lower <= '0;
      cfg_q.upper <= {pwc_pkg::AXES{pwc_pkg::UPPER_RST}};
      cfg_q.factor <= '0;
      cfg_q.walls <= pwc_pkg::WALLS_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

// ===== hw/rtl/pwc_ctrl.sv =====
`default_nettype none
module pwc_ctrl (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output      logic                          in_ready_o,
  output      logic                          out_valid_o,
  input  wire logic                          out_ready_i,
  output      logic [pwc_pkg::NSTAGES-1:0]   en_o
);

  logic [pwc_pkg::NSTAGES-1:0] valid_q, valid_d;
  logic [pwc_pkg::NSTAGES:0]   rdy;

  // A stage loads when it is empty or its content moves on
  always_comb begin
    rdy[pwc_pkg::NSTAGES] = out_ready_i;
    for (int k = pwc_pkg::NSTAGES - 1; k >= 0; k--) begin
      rdy[k] = !valid_q[k] || rdy[k+1];
    end
  end

  assign en_o = rdy[pwc_pkg::NSTAGES-1:0];

  // Advance the valid bits with the data
  always_comb begin
    valid_d = valid_q;
    if (en_o[0]) begin
      valid_d[0] = in_valid_i;
    end
    for (int k = 1; k < pwc_pkg::NSTAGES; k++) begin
      if (en_o[k]) begin
        valid_d[k] = valid_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_ready_o = rdy[0];
  assign out_valid_o = valid_q[pwc_pkg::NSTAGES-1];

`ifndef SYNTH
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[0] && !en_o[0] |=> valid_q[0])
    else $error("stalled first stage lost its item");

  a_full_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (&valid_q))
    else $error("input blocked while a stage is empty");

  a_count_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !(out_valid_o && out_ready_i)
    |=> $countones(valid_q) == $past($countones(valid_q)) + 1)
    else $error("accepted item not counted in the pipeline");

  a_count_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_valid_i && in_ready_o) && out_valid_o && out_ready_i
    |=> $countones(valid_q) == $past($countones(valid_q)) - 1)
    else $error("delivered item not removed from the pipeline");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/pwc_axis.sv =====
`default_nettype none
module pwc_axis (
  input  wire logic                          clk_i,
  input  wire logic [pwc_pkg::NSTAGES-1:0]   en_i,
  input  wire logic [31:0]                   pos_i,
  input  wire logic [31:0]                   vel_i,
  input  wire logic [15:0]                   dt_i,
  input  wire logic [30:0]                   maxd_i,
  input  wire logic                          lo_en_i,
  input  wire logic                          hi_en_i,
  input  wire logic [31:0]                   lower_i,
  input  wire logic [31:0]                   upper_i,
  input  wire logic [pwc_pkg::MIND_W-1:0]    mind_i,
  output      logic [31:0]                   pos_o,
  output      logic [31:0]                   vel_o
);

  localparam int W = pwc_pkg::WIDE_W;

  typedef struct packed {
    logic signed [31:0]                 x;
    logic signed [31:0]                 v;
    logic signed [pwc_pkg::PROD_W-1:0]  pv;
    logic [pwc_pkg::DV_W-1:0]           dv;
    logic [31:0]                        xn;
    logic [30:0]                        maxd;
    logic [pwc_pkg::MIND_W-1:0]         mind;
    logic                               lo_en;
    logic                               hi_en;
    logic                               hit;
    logic signed [W-1:0]                cda;
    logic signed [W-1:0]                cdb;
    logic signed [W-1:0]                cd;
    logic signed [W-1:0]                lim;
  } stage_t;

  stage_t st_q [pwc_pkg::NSTAGES];
  stage_t st_d [pwc_pkg::NSTAGES];

  logic signed [pwc_pkg::PROD_W-1:0] round_sum;
  logic signed [W-1:0]               cd_lo, cd_hi;

  always_comb begin
    // Multiply velocity by time step
    st_d[0] = st_q[0];
    st_d[0].x = pos_i;
    st_d[0].v = vel_i;
    st_d[0].pv = $signed(vel_i) * $signed({1'b0, dt_i});
    st_d[0].maxd = maxd_i;
    st_d[0].lo_en = lo_en_i;
    st_d[0].hi_en = hi_en_i;

    // Round and scale the displacement
    st_d[1] = st_q[0];
    round_sum = st_q[0].pv + pwc_pkg::PHALF;
    st_d[1].dv = round_sum[pwc_pkg::PROD_W-1:pwc_pkg::FRAC_BITS];

    // Predict the position, form the lower threshold
    st_d[2] = st_q[1];
    st_d[2].xn = pwc_pkg::sat32(pwc_pkg::sx32(st_q[1].x) + pwc_pkg::sxdv(st_q[1].dv));
    st_d[2].lim = pwc_pkg::sx32(lower_i) + pwc_pkg::zx31(st_q[1].maxd);
    st_d[2].mind = mind_i;

    // Lower wall: detect contact, candidate stand-offs
    st_d[3] = st_q[2];
    st_d[3].hit = st_q[2].lo_en && (pwc_pkg::sx32(st_q[2].xn) < st_q[2].lim);
    st_d[3].cda = pwc_pkg::sx32(st_q[2].x) - pwc_pkg::sx32(lower_i);
    st_d[3].cdb = pwc_pkg::sx32(st_q[2].xn) - pwc_pkg::sx32(lower_i);

    // Lower wall: pick the stand-off, floor it
    st_d[4] = st_q[3];
    cd_lo = (st_q[3].cda > pwc_pkg::zx31(st_q[3].maxd)) ? st_q[3].cdb : st_q[3].cda;
    if (cd_lo < pwc_pkg::zxm(st_q[3].mind)) begin
      cd_lo = pwc_pkg::zxm(st_q[3].mind);
    end
    st_d[4].cd = cd_lo;

    // Lower wall: push inside, stop outward motion
    st_d[5] = st_q[4];
    st_d[5].lim = pwc_pkg::sx32(lower_i) + st_q[4].cd;
    if (st_q[4].hit) begin
      if (st_d[5].lim > pwc_pkg::sx32(st_q[4].xn)) begin
        st_d[5].xn = pwc_pkg::sat32(st_d[5].lim);
      end
      if (st_q[4].v < 0) begin
        st_d[5].v = '0;
      end
    end

    // Lower wall: rewind position, form the upper threshold
    st_d[6] = st_q[5];
    if (st_q[5].hit) begin
      if (st_q[5].v == 0) begin
        st_d[6].x = st_q[5].xn;
      end else begin
        st_d[6].x = pwc_pkg::sat32(pwc_pkg::sx32(st_q[5].xn) - pwc_pkg::sxdv(st_q[5].dv));
      end
    end
    st_d[6].lim = pwc_pkg::sx32(upper_i) - pwc_pkg::zx31(st_q[5].maxd);

    // Upper wall: detect contact, candidate stand-offs
    st_d[7] = st_q[6];
    st_d[7].hit = st_q[6].hi_en && (pwc_pkg::sx32(st_q[6].xn) > st_q[6].lim);
    st_d[7].cda = pwc_pkg::sx32(upper_i) - pwc_pkg::sx32(st_q[6].x);
    st_d[7].cdb = pwc_pkg::sx32(upper_i) - pwc_pkg::sx32(st_q[6].xn);

    // Upper wall: pick the stand-off, floor it
    st_d[8] = st_q[7];
    cd_hi = (st_q[7].cda > pwc_pkg::zx31(st_q[7].maxd)) ? st_q[7].cdb : st_q[7].cda;
    if (cd_hi < pwc_pkg::zxm(st_q[7].mind)) begin
      cd_hi = pwc_pkg::zxm(st_q[7].mind);
    end
    st_d[8].cd = cd_hi;

    // Upper wall: push inside, stop outward motion
    st_d[9] = st_q[8];
    st_d[9].lim = pwc_pkg::sx32(upper_i) - st_q[8].cd;
    if (st_q[8].hit) begin
      if (st_d[9].lim < pwc_pkg::sx32(st_q[8].xn)) begin
        st_d[9].xn = pwc_pkg::sat32(st_d[9].lim);
      end
      if (st_q[8].v > 0) begin
        st_d[9].v = '0;
      end
    end

    // Upper wall: rewind position
    st_d[10] = st_q[9];
    if (st_q[9].hit) begin
      if (st_q[9].v == 0) begin
        st_d[10].x = st_q[9].xn;
      end else begin
        st_d[10].x = pwc_pkg::sat32(pwc_pkg::sx32(st_q[9].xn) - pwc_pkg::sxdv(st_q[9].dv));
      end
    end
  end

  // Stage registers load when their stage advances
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < pwc_pkg::NSTAGES; k++) begin
      if (en_i[k]) begin
        st_q[k] <= st_d[k];
      end
    end
  end

  assign pos_o = st_q[pwc_pkg::NSTAGES-1].x;
  assign vel_o = st_q[pwc_pkg::NSTAGES-1].v;

endmodule
`default_nettype wire

// ===== hw/rtl/particle_wall_collision_clamp.sv =====
`default_nettype none
// Each particle passes through the 11 register stages, one particle per stage.
// Throughput: one particle per cycle while the master side accepts results.
// A stalled output stage holds its result while empty stages upstream keep filling.
// Reset clears all stage valid bits and loads the configuration defaults;
// stage payload registers are not reset.
module particle_wall_collision_clamp (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [pwc_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [pwc_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  wire logic                             s_axis_tvalid,
  output      logic                             s_axis_tready,
  // particle_tag, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, time_step, max_distance, pad
  input  wire logic [255:0]                     s_axis_tdata,
  // skip_positive
  input  wire logic                             s_axis_tuser,
  output      logic                             m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // result_tag, new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y, new_vel_z
  output      logic [207:0]                     m_axis_tdata
);

  pwc_pkg::cfg_t                  cfg;
  logic [pwc_pkg::NSTAGES-1:0]    en;
  logic [15:0]                    dt;
  logic [30:0]                    maxd;
  logic [pwc_pkg::AXES-1:0][31:0] pos_in, vel_in, pos_out, vel_out;

  logic [pwc_pkg::NSTAGES-1:0][15:0] tag_q;
  logic [pwc_pkg::MPROD_W-2:0]       pm_q;
  logic [pwc_pkg::MIND_W-1:0]        mind_q;
  logic [pwc_pkg::MPROD_W-1:0]       mind_sum;

  pwc_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  pwc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .en_o        (en)
  );

  // Unpack the input transfer
  assign dt = s_axis_tdata[223:208];
  assign maxd = s_axis_tdata[254:224];
  for (genvar a = 0; a < pwc_pkg::AXES; a++) begin : g_unpack
    assign pos_in[a] = s_axis_tdata[16+32*a +: 32];
    assign vel_in[a] = s_axis_tdata[112+32*a +: 32];
  end

  // Minimum stand-off: multiply, then round and scale
  assign mind_sum = {1'b0, pm_q} + pwc_pkg::MHALF;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      pm_q <= {16'd0, maxd} * {31'd0, cfg.factor};
    end
    if (en[1]) begin
      mind_q <= mind_sum[pwc_pkg::MPROD_W-1:pwc_pkg::FRAC_BITS];
    end
  end

  // Carry the tag alongside the particle
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      tag_q[0] <= s_axis_tdata[15:0];
    end
    for (int k = 1; k < pwc_pkg::NSTAGES; k++) begin
      if (en[k]) begin
        tag_q[k] <= tag_q[k-1];
      end
    end
  end

  // One wall pipeline per axis; skipped particles and unused axes see no walls
  for (genvar a = 0; a < pwc_pkg::AXES; a++) begin : g_axis
    pwc_axis u_axis (
      .clk_i   (clk_i),
      .en_i    (en),
      .pos_i   (pos_in[a]),
      .vel_i   (vel_in[a]),
      .dt_i    (dt),
      .maxd_i  (maxd),
      .lo_en_i (!s_axis_tuser && cfg.walls[2*a] && (a < pwc_pkg::DIMS)),
      .hi_en_i (!s_axis_tuser && cfg.walls[2*a+1] && (a < pwc_pkg::DIMS)),
      .lower_i (cfg.lower[a]),
      .upper_i (cfg.upper[a]),
      .mind_i  (mind_q),
      .pos_o   (pos_out[a]),
      .vel_o   (vel_out[a])
    );
  end

  // Pack the result transfer
  assign m_axis_tdata = {vel_out[2], vel_out[1], vel_out[0],
                         pos_out[2], pos_out[1], pos_out[0],
                         tag_q[pwc_pkg::NSTAGES-1]};

endmodule
`default_nettype wire

// ===== verif/particle_clamp_checker.sv =====
`default_nettype none
module particle_clamp_checker (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [pwc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [pwc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                           s_tvalid_i,
  input  wire logic                           s_tready_i,
  // particle_tag, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, time_step, max_distance, pad
  input  wire logic [255:0]                   s_tdata_i,
  // skip_positive
  input  wire logic                           s_tuser_i,
  input  wire logic                           m_tvalid_i,
  input  wire logic                           m_tready_i,
  // result_tag, new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y, new_vel_z
  input  wire logic [207:0]                   m_tdata_i,
  output int                                  mismatches_o,
  output int                                  pending_o
);

  // Shadow copy of the domain registers
  longint      wall_lo [3];
  longint      wall_hi [3];
  logic [15:0] standoff_frac;
  logic [5:0]  wall_mask;

  // Predicted results, oldest first
  logic [207:0] clamped_q [$];
  int           fails;

  function automatic longint sat_q(input longint v);
    if (v > 64'sd2147483647) begin
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      return -64'sd2147483648;
    end
    return v;
  endfunction

  // Product scaled down by 16 bits, round to nearest with ties up
  function automatic longint scale_q16(input longint a, input longint b);
    longint p;
    p = a * b + 64'sd32768;
    return p >>> 16;
  endfunction

  function automatic logic [207:0] clamp_particle(input logic [255:0] d, input logic skip);
    longint       pos [3];
    longint       vel [3];
    longint       dt, maxd, mind, xn, lo, hi, cd, push;
    logic [207:0] r;
    int           a;
    dt   = longint'(d[223:208]);
    maxd = longint'(d[254:224]);
    mind = scale_q16(maxd, longint'(standoff_frac));
    for (a = 0; a < 3; a++) begin
      pos[a] = longint'($signed(d[16+32*a +: 32]));
      vel[a] = longint'($signed(d[112+32*a +: 32]));
    end
    if (!skip) begin
      for (a = 0; a < pwc_pkg::DIMS; a++) begin
        xn = sat_q(pos[a] + scale_q16(vel[a], dt));
        lo = wall_lo[a];
        hi = wall_hi[a];
        // Lower wall: push inside, stop outward motion, rewind
        if (wall_mask[2*a] && xn < lo + maxd) begin
          cd = pos[a] - lo;
          if (cd > maxd) cd = xn - lo;
          if (cd < mind) cd = mind;
          push = lo - xn + cd;
          if (push > 0) xn = sat_q(xn + push);
          if (vel[a] < 0) vel[a] = 0;
          pos[a] = sat_q(xn - scale_q16(vel[a], dt));
        end
        // Upper wall, same rules mirrored
        if (wall_mask[2*a+1] && xn > hi - maxd) begin
          cd = hi - pos[a];
          if (cd > maxd) cd = hi - xn;
          if (cd < mind) cd = mind;
          push = xn - hi + cd;
          if (push > 0) xn = sat_q(xn - push);
          if (vel[a] > 0) vel[a] = 0;
          pos[a] = sat_q(xn - scale_q16(vel[a], dt));
        end
      end
    end
    r[15:0] = d[15:0];
    for (a = 0; a < 3; a++) begin
      r[16+32*a +: 32]  = pos[a][31:0];
      r[112+32*a +: 32] = vel[a][31:0];
    end
    return r;
  endfunction

  function automatic string field_name(input int k);
    case (k)
      0:       return "result_tag";
      1:       return "new_pos_x";
      2:       return "new_pos_y";
      3:       return "new_pos_z";
      4:       return "new_vel_x";
      5:       return "new_vel_y";
      default: return "new_vel_z";
    endcase
  endfunction

  // Track config, queue predictions, check results
  always @(posedge clk_i) begin : watch
    logic [207:0] want;
    logic [31:0]  want_f, got_f;
    int           k;
    if (!rst_ni) begin
      wall_lo       = '{0, 0, 0};
      wall_hi       = '{65536, 65536, 65536};
      standoff_frac = '0;
      wall_mask     = 6'b110111; // upper y open
    end else begin
      if (cfg_we_i) begin
        case (pwc_pkg::cfg_idx_e'(cfg_idx_i))
          pwc_pkg::CFG_LOWER_X: wall_lo[0] = longint'($signed(cfg_data_i));
          pwc_pkg::CFG_LOWER_Y: wall_lo[1] = longint'($signed(cfg_data_i));
          pwc_pkg::CFG_LOWER_Z: wall_lo[2] = longint'($signed(cfg_data_i));
          pwc_pkg::CFG_UPPER_X: wall_hi[0] = longint'($signed(cfg_data_i));
          pwc_pkg::CFG_UPPER_Y: wall_hi[1] = longint'($signed(cfg_data_i));
          pwc_pkg::CFG_UPPER_Z: wall_hi[2] = longint'($signed(cfg_data_i));
          pwc_pkg::CFG_FACTOR:  standoff_frac = cfg_data_i[15:0];
          pwc_pkg::CFG_WALLS:   wall_mask = cfg_data_i[5:0];
          default: ;
        endcase
      end
      if (s_tvalid_i && s_tready_i) begin
        clamped_q.push_back(clamp_particle(s_tdata_i, s_tuser_i));
      end
      if (m_tvalid_i && m_tready_i) begin
        if (clamped_q.size() == 0) begin
          $error("result transfer with no particle pending: %h", m_tdata_i);
          fails++;
        end else begin
          want = clamped_q.pop_front();
          for (k = 0; k < 7; k++) begin
            if (k == 0) begin
              want_f = {16'h0, want[15:0]};
              got_f  = {16'h0, m_tdata_i[15:0]};
            end else begin
              want_f = want[16+32*(k-1) +: 32];
              got_f  = m_tdata_i[16+32*(k-1) +: 32];
            end
            if (want_f !== got_f) begin
              $error("%s: expected %h, actual %h", field_name(k), want_f, got_f);
              fails++;
            end
          end
        end
      end
    end
    mismatches_o <= fails;
    pending_o    <= clamped_q.size();
  end

endmodule
`default_nettype wire

// ===== verif/tb.sv =====
`default_nettype none
module tb;

  localparam int N_PHASES    = 8;
  localparam int PHASE_ITEMS = 205;
  localparam logic [31:0] ONE = 32'h0001_0000;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           cfg_we_i;
  logic [pwc_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [pwc_pkg::CFG_DATA_W-1:0] cfg_data_i;
  logic                           s_axis_tvalid;
  logic                           s_axis_tready;
  // particle_tag, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, time_step, max_distance, pad
  logic [255:0]                   s_axis_tdata;
  // skip_positive
  logic                           s_axis_tuser;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready;
  // result_tag, new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y, new_vel_z
  logic [207:0]                   m_axis_tdata;

  int   mismatches;
  int   pending;
  logic [31:0] aim_lo [3];
  logic [31:0] aim_hi [3];
  bit   send_calm;
  bit   recv_calm;

  particle_wall_collision_clamp dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  particle_clamp_checker chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_i   (s_axis_tready),
    .s_tdata_i    (s_axis_tdata),
    .s_tuser_i    (s_axis_tuser),
    .m_tvalid_i   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_i    (m_axis_tdata),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs
  initial begin
    #5_000_000;
    $display("FAIL particle_wall_collision_clamp");
    $finish;
  end

  // Random magnitude over all scales, random sign
  function automatic logic [31:0] rand_span();
    logic [31:0] m;
    m = $urandom >> $urandom_range(0, 31);
    return $urandom_range(0, 1) ? -m : m;
  endfunction

  task automatic send_particle(input logic [15:0] tag, input logic [2:0][31:0] p,
                               input logic [2:0][31:0] v, input logic [15:0] dt,
                               input logic [30:0] maxd, input logic skip);
    int gap;
    if ($urandom_range(0, 31) == 0) send_calm = !send_calm;
    gap = send_calm ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, maxd, dt, v[2], v[1], v[0], p[2], p[1], p[0], tag};
    s_axis_tuser  <= skip;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic send_random();
    logic [2:0][31:0] p, v;
    logic [15:0]      dt;
    logic [30:0]      maxd;
    logic [31:0]      offs;
    logic             skip;
    int               a;
    if ($urandom_range(0, 9) == 0) begin
      // Raw bits everywhere
      for (a = 0; a < 3; a++) begin
        p[a] = $urandom;
        v[a] = $urandom;
      end
      dt   = 16'($urandom);
      maxd = 31'($urandom);
      skip = 1'($urandom_range(0, 1));
    end else begin
      maxd = 31'($urandom >> $urandom_range(1, 31));
      case ($urandom_range(0, 7))
        0:       dt = 16'h0000;
        1:       dt = 16'hFFFF;
        default: dt = 16'($urandom);
      endcase
      skip = ($urandom_range(0, 9) == 0);
      // Aim each axis at a wall or anywhere, on the scale of the collision distance or any scale
      for (a = 0; a < 3; a++) begin
        v[a] = rand_span();
        if ($urandom_range(0, 1)) begin
          offs = $urandom_range(0, {maxd, 1'b0}) - {1'b0, maxd};
        end else begin
          offs = rand_span();
        end
        case ($urandom_range(0, 4))
          0, 1:    p[a] = aim_lo[a] + offs;
          2, 3:    p[a] = aim_hi[a] + offs;
          default: p[a] = rand_span();
        endcase
      end
    end
    send_particle(16'($urandom), p, v, dt, maxd, skip);
  endtask

  task automatic cfg_write(input pwc_pkg::cfg_idx_e idx, input logic [31:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
  endtask

  task automatic program_domain(input logic [2:0][31:0] lo, input logic [2:0][31:0] hi,
                                input logic [15:0] factor, input logic [5:0] walls);
    logic [31:0] junk;
    int          a;
    junk = $urandom;
    cfg_write(pwc_pkg::CFG_LOWER_X, lo[0]);
    cfg_write(pwc_pkg::CFG_LOWER_Y, lo[1]);
    cfg_write(pwc_pkg::CFG_LOWER_Z, lo[2]);
    cfg_write(pwc_pkg::CFG_UPPER_X, hi[0]);
    cfg_write(pwc_pkg::CFG_UPPER_Y, hi[1]);
    cfg_write(pwc_pkg::CFG_UPPER_Z, hi[2]);
    // Unused upper data bits carry junk
    cfg_write(pwc_pkg::CFG_FACTOR, {junk[31:16], factor});
    cfg_write(pwc_pkg::CFG_WALLS, {junk[31:6], walls});
    cfg_we_i <= 1'b0;
    for (a = 0; a < 3; a++) begin
      aim_lo[a] = lo[a];
      aim_hi[a] = hi[a];
    end
  endtask

  // Drop valid and wait until every particle has come back
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (pwc_pkg::NSTAGES + 4) @(posedge clk_i);
  endtask

  // Result side: random stalls with calm stretches
  initial begin : recv_side
    int gap;
    m_axis_tready <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 31) == 0) recv_calm = !recv_calm;
      gap = recv_calm ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  initial begin : stimulus
    logic [31:0] t;
    logic [31:0] base;
    int          ph;
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= pwc_pkg::CFG_LOWER_X;
    cfg_data_i    <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= 1'b0;
    aim_lo = '{32'h0, 32'h0, 32'h0};
    aim_hi = '{ONE, ONE, ONE};
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed particles under the reset domain [0, 1.0], upper y open
    send_particle(16'h0000, '0, '0, 16'h0000, 31'h0, 1'b0);
    send_particle(16'hFFFF, {32'h1234_5678, 32'h8000_0000, 32'h7FFF_FFFF},
                  {3{32'h8000_0000}}, 16'hFFFF, 31'h7FFF_FFFF, 1'b1);
    send_particle(16'h8001, {3{32'h7FFF_FFFF}}, {3{32'h7FFF_FFFF}}, 16'hFFFF,
                  31'h7FFF_FFFF, 1'b0);
    send_particle(16'h7FFE, {3{32'h8000_0000}}, {3{32'h8000_0000}}, 16'hFFFF,
                  31'h7FFF_FFFF, 1'b0);
    // near the lower walls, moving out
    send_particle(16'h0101, {3{32'h0000_0800}}, {3{-ONE}}, 16'h1000, 31'h2000, 1'b0);
    // near the upper walls, moving out
    send_particle(16'h0202, {3{ONE - 32'h800}}, {3{ONE}}, 16'h1000, 31'h2000, 1'b0);
    // at rest in the middle
    send_particle(16'h0303, {3{ONE >> 1}}, '0, 16'h8000, 31'h1000, 1'b0);
    // already outside below and above
    send_particle(16'h0404, {3{-ONE}}, {3{-(ONE << 1)}}, 16'h8000, 31'h100, 1'b0);
    send_particle(16'h0505, {3{ONE * 3}}, {3{ONE}}, 16'h8000, 31'h100, 1'b0);
    // zero time step against a wall
    send_particle(16'h0606, {3{32'hFFFF_FF00}}, {3{-ONE}}, 16'h0000, 31'h400, 1'b0);
    // zero collision distance
    send_particle(16'h0707, '0, {3{32'hFFFF_FFFF}}, 16'hFFFF, 31'h0, 1'b0);
    // collision distance wider than the domain
    send_particle(16'h0808, {3{ONE >> 1}}, {3{32'h100}}, 16'h0100, 31'h0004_0000, 1'b0);
    // one axis per wall: x low, y high, z far inside
    send_particle(16'h0909, {ONE >> 1, ONE - 32'h10, 32'h10},
                  {32'h0, ONE, -ONE}, 16'h4000, 31'h1000, 1'b0);
    send_particle(16'hAAAA, {32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555},
                  {32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA}, 16'h5555,
                  31'h2AAA_AAAA, 1'b0);
    send_particle(16'h5555, {32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA},
                  {32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555}, 16'hAAAA,
                  31'h5555_5555, 1'b0);
    repeat (8) send_random();

    // Phases with different domains
    for (ph = 0; ph < N_PHASES; ph++) begin
      settle();
      case (ph)
        // +-10.0 box, half stand-off, all walls
        0: program_domain({3{32'hFFF6_0000}}, {3{32'h000A_0000}}, 16'h8000, 6'h3F);
        // widest box, full stand-off
        1: program_domain({3{32'h8000_0000}}, {3{32'h7FFF_FFFF}}, 16'hFFFF, 6'h3F);
        // inverted box
        2: program_domain({3{32'h0005_0000}}, {3{32'hFFFB_0000}}, 16'h4000, 6'h3F);
        // zero-size box
        3: begin
          t = rand_span() >> 8;
          program_domain({3{t}}, {3{t}}, 16'hFFFF, 6'($urandom));
        end
        // all walls open
        4: program_domain('0, {3{ONE}}, 16'h0000, 6'h00);
        // inverted to the extremes
        5: program_domain({3{32'h7FFF_FFFF}}, {3{32'h8000_0000}}, 16'($urandom), 6'h3F);
        default: begin
          base = rand_span();
          program_domain({base, rand_span(), base},
                         {base + ($urandom >> $urandom_range(4, 31)), rand_span(),
                          base + ($urandom >> $urandom_range(4, 31))},
                         16'($urandom), 6'($urandom));
        end
      endcase
      repeat (PHASE_ITEMS) send_random();
    end

    settle();
    if (mismatches == 0 && pending == 0) begin
      $display("PASS particle_wall_collision_clamp");
    end else begin
      $display("FAIL particle_wall_collision_clamp");
    end
    $finish;
  end

endmodule
`default_nettype wire
